### sv/lkvc_pkg.sv
// lkvc_pkg: shared constants, types and command codes for the lru key-value cache
package lkvc_pkg;

   localparam int Entries   = 8;
   localparam int KeyBits   = 32;
   localparam int DataBits  = 32;
   localparam int CapBits   = 4;
   localparam int IdxBits   = (Entries > 1) ? $clog2(Entries) : 1;
   localparam int StoreBits = (KeyBits < DataBits) ? KeyBits : DataBits;

   localparam logic [CapBits-1:0] CapReset = CapBits'(8);

   localparam logic CmdInsert = 1'b0;
   localparam logic CmdLookup = 1'b1;

   typedef logic [StoreBits-1:0]       skey_type;
   typedef logic signed [DataBits-1:0] data_type;

   typedef struct packed {
      skey_type key;
      data_type value;
      logic     valid;
   } entry_type;

   typedef struct packed {
      logic     go;
      logic     hit_mode;
      logic     ins_miss;
      logic     evict;
      skey_type key;
   } cell_ctl_type;

   typedef struct packed {
      logic                hit;
      data_type            read_value;
      logic [DataBits-1:0] recent_key;
      logic                recent_valid;
   } rsp_type;

endpackage

### sv/lkvc_req_if.sv
// lkvc_req_if: request channel carrying command, key and value beats
interface lkvc_req_if;
   logic                     valid;
   logic                     ready;
   logic                     command;
   logic [31:0]              key;
   logic signed [31:0]       value;

   modport source (output valid, output command, output key, output value, input ready);
   modport sink   (input valid, input command, input key, input value, output ready);
endinterface

### sv/lkvc_rsp_if.sv
// lkvc_rsp_if: response channel carrying hit, read value and most recent key beats
interface lkvc_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     hit;
   logic signed [31:0]       read_value;
   logic [31:0]              recent_key;
   logic                     recent_valid;

   modport source (output valid, output hit, output read_value, output recent_key,
                   output recent_valid, input ready);
   modport sink   (input valid, input hit, input read_value, input recent_key,
                   input recent_valid, output ready);
endinterface

### sv/lkvc_cell.sv
// lkvc_cell: one recency-ordered entry slot that compares its key and shifts from its neighbor
module lkvc_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  lkvc_pkg::cell_ctl_type ctl,
   input  lkvc_pkg::entry_type   prev,
   input  logic                  tail_in,
   output lkvc_pkg::entry_type   ent,
   output logic                  match,
   output logic                  tail_out
);

   lkvc_pkg::skey_type key_ff, key_in;
   lkvc_pkg::data_type value_ff, value_in;
   logic               valid_ff, valid_in;
   logic               shift;

   assign match    = valid_ff && (key_ff == ctl.key);
   assign tail_out = match | tail_in;

   // hit: every cell at or above the hit position moves down one place
   // new key: the used prefix moves down, dropping the last entry on eviction
   always_comb begin
      priority if (ctl.hit_mode) begin
         shift = tail_out;
      end else if (ctl.ins_miss) begin
         shift = ctl.evict ? valid_ff : prev.valid;
      end else begin
         shift = 1'b0;
      end
      if (ctl.go && shift) begin
         key_in   = prev.key;
         value_in = prev.value;
         valid_in = prev.valid;
      end else begin
         key_in   = key_ff;
         value_in = value_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign ent.key   = key_ff;
   assign ent.value = value_ff;
   assign ent.valid = valid_ff;

endmodule

### sv/lru_key_value_cache_core.sv
// lru_key_value_cache_core: fully associative key-value cache with lru replacement
//
// Entries sit in a row of cells kept in recency order, cell 0 the most recent.
// Each request beat is compared against every cell in the same cycle; a hit or
// a new key shifts the cells in front of the affected position down by one and
// loads the request entry into cell 0, so eviction always drops the last used
// cell. A beat is accepted every cycle while the response register is empty or
// being drained; the compare and shift across the row complete in the accepting
// cycle, and the registered response appears in the cycle after. Capacity is
// written through csr_we/csr_wdata by the user only while idle, unenforced by
// the block; zero acts as one and values above the entry count act as the entry count.
module lru_key_value_cache_core (
   input  logic                              clock,
   input  logic                              reset,
   lkvc_req_if.sink                          req_chan,
   lkvc_rsp_if.source                        rsp_chan,
   input  logic                              csr_we,
   input  logic [lkvc_pkg::CapBits-1:0]      csr_wdata
);

   logic [lkvc_pkg::CapBits-1:0] csr_cap_ff, csr_cap_in;
   logic [lkvc_pkg::IdxBits-1:0] cap_idx;

   lkvc_pkg::entry_type           ent [lkvc_pkg::Entries];
   lkvc_pkg::entry_type           front;
   logic [lkvc_pkg::Entries-1:0]  match_vec;
   logic [lkvc_pkg::Entries-1:0]  vld_vec;
   logic [lkvc_pkg::Entries:0]    tail;
   lkvc_pkg::cell_ctl_type        ctl;
   lkvc_pkg::skey_type            req_key;
   lkvc_pkg::data_type            match_value;

   logic                          go;
   logic                          hit;
   logic                          evict;
   logic                          is_insert;

   logic                          rsp_valid_ff, rsp_valid_in;
   lkvc_pkg::rsp_type             rsp_ff, rsp_in;

   assign csr_cap_in = csr_we ? csr_wdata : csr_cap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_cap_ff <= lkvc_pkg::CapReset;
      end else begin
         csr_cap_ff <= csr_cap_in;
      end
   end

   always_comb begin
      priority if (csr_cap_ff == '0) begin
         cap_idx = '0;
      end else if (32'(csr_cap_ff) > lkvc_pkg::Entries) begin
         cap_idx = lkvc_pkg::IdxBits'(lkvc_pkg::Entries - 1);
      end else begin
         cap_idx = lkvc_pkg::IdxBits'(csr_cap_ff - lkvc_pkg::CapBits'(1));
      end
   end

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign go             = req_chan.valid && req_chan.ready;
   assign req_key        = lkvc_pkg::StoreBits'(req_chan.key);
   assign is_insert      = (req_chan.command == lkvc_pkg::CmdInsert);
   assign hit            = tail[0];
   assign evict          = vld_vec[cap_idx];

   always_comb begin
      match_value = '0;
      for (int i = 0; i < lkvc_pkg::Entries; i++) begin
         if (match_vec[i]) begin
            match_value = match_value | ent[i].value;
         end
      end
   end

   assign front.key   = req_key;
   assign front.value = is_insert ? req_chan.value : match_value;
   assign front.valid = 1'b1;

   assign ctl.go       = go;
   assign ctl.hit_mode = hit;
   assign ctl.ins_miss = is_insert && !hit;
   assign ctl.evict    = evict;
   assign ctl.key      = req_key;

   assign tail[lkvc_pkg::Entries] = 1'b0;

   for (genvar i = 0; i < lkvc_pkg::Entries; i++) begin : g_cell
      lkvc_pkg::entry_type prev;
      if (i == 0) begin : g_head
         assign prev = front;
      end else begin : g_link
         assign prev = ent[i-1];
      end
      lkvc_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .prev     (prev),
         .tail_in  (tail[i+1]),
         .ent      (ent[i]),
         .match    (match_vec[i]),
         .tail_out (tail[i])
      );
      assign vld_vec[i] = ent[i].valid;
   end

   always_comb begin
      rsp_in.hit        = hit;
      rsp_in.read_value = (!is_insert && hit) ? match_value : '0;
      if (is_insert || hit) begin
         rsp_in.recent_key   = lkvc_pkg::DataBits'(req_key);
         rsp_in.recent_valid = 1'b1;
      end else begin
         rsp_in.recent_key   = ent[0].valid ? lkvc_pkg::DataBits'(ent[0].key) : '0;
         rsp_in.recent_valid = ent[0].valid;
      end
   end

   always_comb begin
      priority if (go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         rsp_ff <= rsp_in;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.hit          = rsp_ff.hit;
   assign rsp_chan.read_value   = rsp_ff.read_value;
   assign rsp_chan.recent_key   = rsp_ff.recent_key;
   assign rsp_chan.recent_valid = rsp_ff.recent_valid;

   // used cells always form a prefix of the row
   a_valid_prefix: assert property (@(posedge clock) disable iff (reset)
      (vld_vec & (vld_vec + lkvc_pkg::Entries'(1))) == '0)
      else $error("valid cells are not a prefix");

   // keys are unique, so at most one cell matches
   a_single_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("more than one cell matches the key");

   // an accepted insert always leaves a most recent entry
   a_insert_recent: assert property (@(posedge clock) disable iff (reset)
      go && is_insert |=> rsp_valid_ff && rsp_ff.recent_valid)
      else $error("insert beat without a most recent entry");

   // a lookup miss leaves the row untouched
   a_miss_stable: assert property (@(posedge clock) disable iff (reset)
      go && !is_insert && !hit |=> $stable(vld_vec))
      else $error("lookup miss changed the row");

   // a new key without eviction adds exactly one entry
   a_insert_grow: assert property (@(posedge clock) disable iff (reset)
      go && is_insert && !hit && !evict |=>
      $countones(vld_vec) == $countones($past(vld_vec)) + 1)
      else $error("insert without eviction did not add an entry");

endmodule

### verif/lru_key_value_cache_core_checker.sv
// lru_key_value_cache_core_checker: shadow lru store that predicts and checks every response beat
module lru_key_value_cache_core_checker (
   input  logic                         clock,
   input  logic                         reset,
   lkvc_req_if                          req_mon,
   lkvc_rsp_if                          rsp_mon,
   input  logic                         csr_we,
   input  logic [lkvc_pkg::CapBits-1:0] csr_wdata,
   output int                           mismatch_count,
   output int                           outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [31:0]                  shadow_key [lkvc_pkg::Entries];
   lkvc_pkg::data_type           shadow_value [lkvc_pkg::Entries];
   logic                         shadow_valid [lkvc_pkg::Entries];
   int                           shadow_rank [lkvc_pkg::Entries];
   int                           shadow_count;
   logic [lkvc_pkg::CapBits-1:0] shadow_capacity;
   lkvc_pkg::rsp_type            expected_rsp_q [$];
   int                           fail_tally = 0;

   assign mismatch_count = fail_tally;

   function automatic void shadow_clear();
      for (int i = 0; i < lkvc_pkg::Entries; i++) begin
         shadow_key[i] = '0;
         shadow_value[i] = '0;
         shadow_valid[i] = 1'b0;
         shadow_rank[i] = 0;
      end
      shadow_count = 0;
      shadow_capacity = lkvc_pkg::CapReset;
   endfunction

   // move a valid entry to the front, entries ahead of it age by one
   function automatic void promote(int idx);
      int old_rank;
      old_rank = shadow_rank[idx];
      for (int i = 0; i < lkvc_pkg::Entries; i++)
         if (shadow_valid[i] && shadow_rank[i] < old_rank) shadow_rank[i]++;
      shadow_rank[idx] = 0;
   endfunction

   function automatic lkvc_pkg::rsp_type lru_access(logic cmd, logic [31:0] k,
                                                   lkvc_pkg::data_type v);
      lkvc_pkg::rsp_type r;
      int                found;
      int                victim;
      int                slot;
      int                limit;
      r = '0;
      found = -1;
      victim = -1;
      slot = -1;
      limit = (shadow_capacity == 0) ? 1 :
              (int'(shadow_capacity) > lkvc_pkg::Entries) ? lkvc_pkg::Entries :
              int'(shadow_capacity);
      for (int i = 0; i < lkvc_pkg::Entries; i++)
         if (found < 0 && shadow_valid[i] && shadow_key[i] == k) found = i;
      r.hit = (found >= 0);
      if (cmd == lkvc_pkg::CmdInsert) begin
         if (found >= 0) begin
            shadow_value[found] = v;
            promote(found);
         end else begin
            if (shadow_count >= limit) begin
               for (int i = 0; i < lkvc_pkg::Entries; i++)
                  if (shadow_valid[i] &&
                      (victim < 0 || shadow_rank[i] > shadow_rank[victim])) victim = i;
               if (victim >= 0) begin
                  shadow_valid[victim] = 1'b0;
                  shadow_count--;
               end
            end
            for (int i = 0; i < lkvc_pkg::Entries; i++)
               if (slot < 0 && !shadow_valid[i]) slot = i;
            if (slot >= 0) begin
               for (int i = 0; i < lkvc_pkg::Entries; i++)
                  if (shadow_valid[i]) shadow_rank[i]++;
               shadow_key[slot] = k;
               shadow_value[slot] = v;
               shadow_valid[slot] = 1'b1;
               shadow_rank[slot] = 0;
               shadow_count++;
            end
         end
      end else if (found >= 0) begin
         r.read_value = shadow_value[found];
         promote(found);
      end
      for (int i = 0; i < lkvc_pkg::Entries; i++)
         if (!r.recent_valid && shadow_valid[i] && shadow_rank[i] == 0) begin
            r.recent_key = shadow_key[i];
            r.recent_valid = 1'b1;
         end
      return r;
   endfunction

   function automatic void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %h, actual %h", name, want, got);
         fail_tally++;
      end
   endfunction

   initial shadow_clear();

   always @(posedge clock) begin
      lkvc_pkg::rsp_type want;
      if (reset) begin
         shadow_clear();
         expected_rsp_q.delete();
      end else begin
         // response first so a beat cannot be matched against its own request
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_rsp_q.size() == 0) begin
               $error("unexpected response beat: hit %b read_value %h recent_key %h",
                      rsp_mon.hit, rsp_mon.read_value, rsp_mon.recent_key);
               fail_tally++;
            end else begin
               want = expected_rsp_q.pop_front();
               field_check("hit", 32'(want.hit), 32'(rsp_mon.hit));
               field_check("read_value", want.read_value, rsp_mon.read_value);
               field_check("recent_key", want.recent_key, rsp_mon.recent_key);
               field_check("recent_valid", 32'(want.recent_valid), 32'(rsp_mon.recent_valid));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_rsp_q.push_back(lru_access(req_mon.command, req_mon.key, req_mon.value));
         if (csr_we) shadow_capacity = csr_wdata;
      end
      outstanding = expected_rsp_q.size();
   end

endmodule

### verif/lru_key_value_cache_core_tb.sv
// lru_key_value_cache_core_tb: stimulus, capacity phases and verdict for the lru key-value cache
module lru_key_value_cache_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         csr_we = 1'b0;
   logic [lkvc_pkg::CapBits-1:0] csr_wdata = '0;
   int                           mismatch_count;
   int                           outstanding;
   int                           burst_left = 0;
   int unsigned                  drain_cycle = 0;
   int unsigned                  drain_mode = 0;
   logic [31:0]                  key_pool [12];

   lkvc_req_if req_chan ();
   lkvc_rsp_if rsp_chan ();

   lru_key_value_cache_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   lru_key_value_cache_core_checker lru_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("TEST FAILED");
      $finish;
   end

   // response stall pattern, switching at random among four styles
   always @(negedge clock) begin
      drain_cycle++;
      if (drain_cycle % 48 == 0) drain_mode = $urandom_range(0, 3);
      unique case (drain_mode)
         0: rsp_chan.ready = 1'b1;
         1: rsp_chan.ready = 1'($urandom_range(0, 1));
         2: rsp_chan.ready = (drain_cycle % 4 == 0);
         default: rsp_chan.ready = ($urandom_range(0, 9) == 0);
      endcase
   end

   // called and returns at a falling edge; valid stays high for a following beat
   task automatic send_beat(logic cmd, logic [31:0] k, logic [31:0] v);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 4);
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? 64 : $urandom_range(1, 10);
      end
      burst_left--;
      req_chan.valid = 1'b1;
      req_chan.command = cmd;
      req_chan.key = k;
      req_chan.value = v;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic drain_all();
      req_chan.valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic set_capacity(logic [lkvc_pkg::CapBits-1:0] cap);
      drain_all();
      csr_we = 1'b1;
      csr_wdata = cap;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic random_phase(int count);
      int          pool_used;
      int          pick;
      logic [31:0] k;
      pool_used = $urandom_range(2, 12);
      for (int p = 0; p < 12; p++) key_pool[p] = $urandom;
      if ($urandom_range(0, 2) == 0) key_pool[0] = '0;
      if ($urandom_range(0, 2) == 0) key_pool[1] = '1;
      repeat (count) begin
         pick = $urandom_range(0, pool_used + 1);
         k = (pick < pool_used) ? key_pool[pick] : $urandom;
         send_beat($urandom_range(0, 1) ? lkvc_pkg::CmdLookup : lkvc_pkg::CmdInsert, k,
                   $urandom);
      end
   endtask

   initial begin
      logic [lkvc_pkg::CapBits-1:0] phase_cap [11];
      phase_cap = '{4'd1, 4'd0, 4'd15, 4'd8, 4'd3, 4'd2, 4'd9, 4'd5, 4'd4, 4'd7, 4'd6};
      req_chan.valid = 1'b0;
      req_chan.command = lkvc_pkg::CmdInsert;
      req_chan.key = '0;
      req_chan.value = '0;
      rsp_chan.ready = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      set_capacity(4'd8);
      send_beat(lkvc_pkg::CmdLookup, 32'h0000_0000, 32'h1111_1111);
      send_beat(lkvc_pkg::CmdInsert, 32'h0000_0000, 32'h8000_0000);
      send_beat(lkvc_pkg::CmdInsert, 32'hffff_ffff, 32'h7fff_ffff);
      send_beat(lkvc_pkg::CmdLookup, 32'hffff_ffff, 32'h0000_0000);
      send_beat(lkvc_pkg::CmdLookup, 32'h0000_0000, 32'hffff_ffff);
      send_beat(lkvc_pkg::CmdInsert, 32'h0000_0000, 32'h0000_0000);
      send_beat(lkvc_pkg::CmdLookup, 32'h1234_5678, 32'h0000_0000);
      for (int i = 1; i <= 6; i++) send_beat(lkvc_pkg::CmdInsert, 32'(i), 32'(-i));
      send_beat(lkvc_pkg::CmdInsert, 32'd100, 32'hdead_beef);
      send_beat(lkvc_pkg::CmdLookup, 32'hffff_ffff, 32'h0000_0000);

      // shrink below the current fill: one eviction per new key
      set_capacity(4'd2);
      send_beat(lkvc_pkg::CmdInsert, 32'd200, 32'h0000_00c8);
      send_beat(lkvc_pkg::CmdInsert, 32'd201, 32'h0000_00c9);
      send_beat(lkvc_pkg::CmdLookup, 32'd6, 32'h0000_0000);

      set_capacity(4'd0);
      send_beat(lkvc_pkg::CmdInsert, 32'd300, 32'h5555_5555);
      send_beat(lkvc_pkg::CmdLookup, 32'd300, 32'h0000_0000);
      send_beat(lkvc_pkg::CmdLookup, 32'd201, 32'h0000_0000);

      set_capacity(4'd15);
      send_beat(lkvc_pkg::CmdInsert, 32'd400, 32'haaaa_aaaa);
      send_beat(lkvc_pkg::CmdInsert, 32'd401, 32'h0000_0001);

      foreach (phase_cap[p]) begin
         set_capacity(phase_cap[p]);
         random_phase(170);
      end

      drain_all();
      repeat (4) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
